// ===== rtl/ttb_pkg.sv =====
// Shared constants for the triangle tangent and bitangent block.
package ttb_pkg;

   localparam int NORM_BITS = 30;
   localparam int HALF_SHIFT = 15;
   localparam int SUM_W = 64;
   localparam int ROOT_W = 32;
   localparam int NUM_W = 46;
   localparam int DEN_W = ROOT_W + 1;
   localparam int QUO_W = 16;
   localparam int OUT_W = 16;
   localparam int RSP_W = 6 * OUT_W;
   localparam int PROD_CNT = 14;
   localparam int PROD_CNT_W = 4;

endpackage

// ===== rtl/ttb_mul.sv =====
// Iterative unsigned multiplier, one 4-bit digit of the second operand per cycle.
module ttb_mul #(
   parameter int WIDTH = 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic               done,
   output logic [2*WIDTH-1:0] product
);
   localparam int NDIG = (WIDTH + 3) / 4;
   localparam int BW = NDIG * 4;
   localparam int CNT_W = $clog2(NDIG + 1);

   logic [2*WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0]   a_ff, a_in;
   logic [BW-1:0]      b_ff, b_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         a_in = op_a;
         b_in = BW'(op_b);
         cnt_in = CNT_W'(NDIG);
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = (acc_ff << 4) + ((2*WIDTH)'(a_ff) * (2*WIDTH)'(b_ff[BW-1 -: 4]));
         b_in = b_ff << 4;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// ===== rtl/ttb_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
module ttb_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ttb_pkg::SUM_W-1:0]  radicand,
   output logic                       done,
   output logic [ttb_pkg::ROOT_W-1:0] root
);
   import ttb_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SUM_W-1:0]  x_ff, x_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  shifted;
   logic [REM_W-1:0]  trial;

   always_comb begin
      shifted = {rem_ff[REM_W-3:0], x_ff[SUM_W-1 -: 2]};
      trial = REM_W'({root_ff, 2'b01});
      rem_in = rem_ff;
      root_in = root_ff;
      x_in = x_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         root_in = '0;
         x_in = radicand;
         cnt_in = CNT_W'(ROOT_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         x_in = x_ff << 2;
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      x_ff <= x_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// ===== rtl/ttb_div.sv =====
// Iterative restoring divider for the rounded unit-vector components.
module ttb_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ttb_pkg::NUM_W-1:0] dividend,
   input  logic [ttb_pkg::DEN_W-1:0] divisor,
   output logic                      done,
   output logic [ttb_pkg::QUO_W-1:0] quotient
);
   import ttb_pkg::*;

   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] low_ff, low_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] trial;

   always_comb begin
      trial = {rem_ff[REM_W-2:0], low_ff[QUO_W-1]};
      rem_in = rem_ff;
      den_in = den_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = REM_W'(dividend[NUM_W-1:QUO_W]);
         low_in = dividend[QUO_W-1:0];
         den_in = divisor;
         quo_in = '0;
         cnt_in = CNT_W'(QUO_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         low_in = low_ff << 1;
         if (trial >= REM_W'(den_ff)) begin
            rem_in = trial - REM_W'(den_ff);
            quo_in = {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[QUO_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/triangle_tangent_bitangent.sv =====
// Top level: unit tangent and bitangent of a triangle from its vertex UVs.
//
// The req channel carries one vertex per item: position x, y, z and texture
// u, v, each COORD_WIDTH bits two's complement (Q16.16 at 32 bits). The
// first two vertices of a triangle are held; the third starts the work and
// yields one rsp item with the Q2.14 unit tangent and bitangent, plus a
// degenerate flag in rsp_tuser (vectors zero when set).
// The third vertex starts 14 products on the shared digit-serial
// multiplier, then per vector a load and normalizing shifts, 3 squares on the
// same multiplier, a square root and 3 divisions.
// req_tready is low while a triangle is in work.
// A finished result waits in an output register; the next vertices are
// taken while it waits, and a following triangle holds before its result
// until that register is free. Reset empties the vertex slot and drops any
// pending result.
module triangle_tangent_bitangent #(
   parameter  int COORD_WIDTH = 32,
   localparam int REQ_W = ((5 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, zero fill
   input  logic [REQ_W-1:0]          req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // tan_x, tan_y, tan_z, btan_x, btan_y, btan_z
   output logic [ttb_pkg::RSP_W-1:0] rsp_tdata,
   // degenerate
   output logic                      rsp_tuser
);
   import ttb_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int DW = CW + 1;
   localparam int MW = 2 * DW;
   localparam int VW = MW + 1;
   localparam int OPW = (DW > NORM_BITS) ? DW : NORM_BITS;

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_MUL_GO    = 12'b000000000010,
      S_MUL_WAIT  = 12'b000000000100,
      S_NRM_LOAD  = 12'b000000001000,
      S_NRM_SHIFT = 12'b000000010000,
      S_SQ_GO     = 12'b000000100000,
      S_SQ_WAIT   = 12'b000001000000,
      S_SQRT_GO   = 12'b000010000000,
      S_SQRT_WAIT = 12'b000100000000,
      S_DIV_GO    = 12'b001000000000,
      S_DIV_WAIT  = 12'b010000000000,
      S_OUT       = 12'b100000000000
   } state_type;

   function automatic logic signed [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
   endfunction

   function automatic logic [OPW-1:0] magn(input logic signed [DW-1:0] x);
      logic [DW-1:0] u;
      u = x[DW-1] ? DW'(-x) : DW'(x);
      return OPW'(u);
   endfunction

   state_type state_ff, state_in;
   logic [1:0] slot_ff, slot_in;
   logic [CW-1:0] hp_ff [6];
   logic [CW-1:0] hp_in [6];
   logic [CW-1:0] ht_ff [4];
   logic [CW-1:0] ht_in [4];
   logic signed [DW-1:0] e1_ff [3];
   logic signed [DW-1:0] e1_in [3];
   logic signed [DW-1:0] e2_ff [3];
   logic signed [DW-1:0] e2_in [3];
   logic signed [DW-1:0] du1_ff, du1_in, dv1_ff, dv1_in, du2_ff, du2_in, dv2_ff, dv2_in;
   logic [PROD_CNT_W-1:0] k_ff, k_in;
   logic psign_ff, psign_in;
   logic [VW-1:0] acc_ff, acc_in;
   logic [VW-1:0] det_ff, det_in;
   logic [VW-1:0] vec_ff [6];
   logic [VW-1:0] vec_in [6];
   logic [MW-1:0] m_ff [3];
   logic [MW-1:0] m_in [3];
   logic [2:0] neg_ff, neg_in;
   logic nsel_ff, nsel_in;
   logic [1:0] j_ff, j_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [ROOT_W-1:0] len_ff, len_in;
   logic [OUT_W-1:0] res_ff [6];
   logic [OUT_W-1:0] res_in [6];
   logic deg_ff, deg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   logic [CW-1:0] in_f [5];
   logic [2:0] pair;
   logic signed [DW-1:0] opa, opb;
   logic [OPW-1:0] mul_a, mul_b;
   logic mul_start, mul_done;
   logic [2*OPW-1:0] mul_prod;
   logic [VW-1:0] pmag, sprod, pdiff;
   logic sqrt_start, sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;
   logic div_start, div_done;
   logic [NUM_W-1:0] div_num;
   logic [QUO_W-1:0] div_quo;
   logic [OUT_W-1:0] cval;
   logic [2:0] base;
   logic [VW-1:0] ld;
   logic hi_any, top_any, all_zero;
   logic [RSP_W-1:0] packed_res;

   assign req_tready = (state_ff == S_IDLE);
   assign pair = k_ff[PROD_CNT_W-1:1];

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         in_f[i] = req_tdata[i*CW +: CW];
      end
      for (int i = 0; i < 6; i++) begin
         packed_res[i*OUT_W +: OUT_W] = res_ff[i];
      end
   end

   always_comb begin
      opa = '0;
      opb = '0;
      unique case (pair)
         3'd0: begin
            opa = k_ff[0] ? du2_ff : du1_ff;
            opb = k_ff[0] ? dv1_ff : dv2_ff;
         end
         3'd1, 3'd2, 3'd3: begin
            opa = k_ff[0] ? dv1_ff : dv2_ff;
            opb = k_ff[0] ? e2_ff[2'(pair - 3'd1)] : e1_ff[2'(pair - 3'd1)];
         end
         3'd4, 3'd5, 3'd6: begin
            opa = k_ff[0] ? du2_ff : du1_ff;
            opb = k_ff[0] ? e1_ff[2'(pair - 3'd4)] : e2_ff[2'(pair - 3'd4)];
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      if (state_ff == S_SQ_GO) begin
         mul_a = OPW'(m_ff[j_ff][NORM_BITS-1:0]);
         mul_b = OPW'(m_ff[j_ff][NORM_BITS-1:0]);
      end else begin
         mul_a = magn(opa);
         mul_b = magn(opb);
      end
      mul_start = (state_ff == S_MUL_GO) || (state_ff == S_SQ_GO);
      sqrt_start = (state_ff == S_SQRT_GO);
      div_start = (state_ff == S_DIV_GO);
      div_num = NUM_W'({m_ff[j_ff][NORM_BITS-1:0], {HALF_SHIFT{1'b0}}}) + NUM_W'(len_ff);
      pmag = VW'(mul_prod);
      sprod = psign_ff ? (-pmag) : pmag;
      pdiff = acc_ff - sprod;
      cval = neg_ff[j_ff] ? (-div_quo) : div_quo;
      base = nsel_ff ? 3'd3 : 3'd0;
      hi_any = |(m_ff[0][MW-1:NORM_BITS] | m_ff[1][MW-1:NORM_BITS] | m_ff[2][MW-1:NORM_BITS]);
      top_any = m_ff[0][NORM_BITS-1] | m_ff[1][NORM_BITS-1] | m_ff[2][NORM_BITS-1];
   end

   ttb_mul #(.WIDTH(OPW)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .op_a(mul_a), .op_b(mul_b),
      .done(mul_done), .product(mul_prod)
   );

   ttb_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sum_ff),
      .done(sqrt_done), .root(sqrt_root)
   );

   ttb_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor({len_ff, 1'b0}), .done(div_done), .quotient(div_quo)
   );

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      hp_in = hp_ff;
      ht_in = ht_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      du1_in = du1_ff;
      dv1_in = dv1_ff;
      du2_in = du2_ff;
      dv2_in = dv2_ff;
      k_in = k_ff;
      psign_in = psign_ff;
      acc_in = acc_ff;
      det_in = det_ff;
      vec_in = vec_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      nsel_in = nsel_ff;
      j_in = j_ff;
      sum_in = sum_ff;
      len_in = len_ff;
      res_in = res_ff;
      deg_in = deg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      ld = '0;
      all_zero = 1'b1;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (slot_ff == 2'd2) begin
                  for (int i = 0; i < 3; i++) begin
                     e1_in[i] = diff(hp_ff[3+i], hp_ff[i]);
                     e2_in[i] = diff(in_f[i], hp_ff[i]);
                  end
                  du1_in = diff(ht_ff[2], ht_ff[0]);
                  dv1_in = diff(ht_ff[3], ht_ff[1]);
                  du2_in = diff(in_f[3], ht_ff[0]);
                  dv2_in = diff(in_f[4], ht_ff[1]);
                  slot_in = 2'd0;
                  k_in = '0;
                  nsel_in = 1'b0;
                  deg_in = 1'b0;
                  state_in = S_MUL_GO;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     if (slot_ff == 2'd1) begin
                        hp_in[3+i] = in_f[i];
                     end else begin
                        hp_in[i] = in_f[i];
                     end
                  end
                  if (slot_ff == 2'd1) begin
                     ht_in[2] = in_f[3];
                     ht_in[3] = in_f[4];
                     slot_in = 2'd2;
                  end else begin
                     ht_in[0] = in_f[3];
                     ht_in[1] = in_f[4];
                     slot_in = 2'd1;
                  end
               end
            end
         end
         S_MUL_GO: begin
            psign_in = opa[DW-1] ^ opb[DW-1];
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               if (!k_ff[0]) begin
                  acc_in = sprod;
               end else if (pair == 3'd0) begin
                  det_in = pdiff;
               end else begin
                  vec_in[3'(pair - 3'd1)] = pdiff;
               end
               if (k_ff == PROD_CNT_W'(PROD_CNT - 1)) begin
                  state_in = S_NRM_LOAD;
               end else begin
                  k_in = k_ff + PROD_CNT_W'(1);
                  state_in = S_MUL_GO;
               end
            end
         end
         S_NRM_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               ld = vec_ff[3'(base + 3'(i))];
               neg_in[i] = ld[VW-1] ^ det_ff[VW-1];
               m_in[i] = ld[VW-1] ? MW'(-ld) : MW'(ld);
               if (ld != '0) begin
                  all_zero = 1'b0;
               end
            end
            if (det_ff == '0 || all_zero) begin
               deg_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_NRM_SHIFT;
            end
         end
         S_NRM_SHIFT: begin
            priority if (hi_any) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] >> 1;
               end
            end else if (!top_any) begin
               for (int i = 0; i < 3; i++) begin
                  m_in[i] = m_ff[i] << 1;
               end
            end else begin
               j_in = 2'd0;
               sum_in = '0;
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (mul_done) begin
               sum_in = sum_ff + SUM_W'(mul_prod[2*NORM_BITS-1:0]);
               if (j_ff == 2'd2) begin
                  state_in = S_SQRT_GO;
               end else begin
                  j_in = j_ff + 2'd1;
                  state_in = S_SQ_GO;
               end
            end
         end
         S_SQRT_GO: begin
            state_in = S_SQRT_WAIT;
         end
         S_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_in = sqrt_root;
               j_in = 2'd0;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_in[3'(base + 3'(j_ff))] = cval;
               if (j_ff != 2'd2) begin
                  j_in = j_ff + 2'd1;
                  state_in = S_DIV_GO;
               end else if (nsel_ff) begin
                  state_in = S_OUT;
               end else begin
                  nsel_in = 1'b1;
                  state_in = S_NRM_LOAD;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = deg_ff ? '0 : packed_res;
               rsp_user_in = deg_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hp_ff <= hp_in;
      ht_ff <= ht_in;
      e1_ff <= e1_in;
      e2_ff <= e2_in;
      du1_ff <= du1_in;
      dv1_ff <= dv1_in;
      du2_ff <= du2_in;
      dv2_ff <= dv2_in;
      k_ff <= k_in;
      psign_ff <= psign_in;
      acc_ff <= acc_in;
      det_ff <= det_in;
      vec_ff <= vec_in;
      m_ff <= m_in;
      neg_ff <= neg_in;
      nsel_ff <= nsel_in;
      j_ff <= j_in;
      sum_ff <= sum_in;
      len_ff <= len_in;
      res_ff <= res_in;
      deg_ff <= deg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (reset) begin
         state_ff <= S_IDLE;
         slot_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == '0))
      else $error("degenerate result carries nonzero vectors");

   a_stay_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !(req_tvalid && slot_ff == 2'd2)) |=> (state_ff == S_IDLE))
      else $error("work started without a third vertex");

   a_tan_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_user_ff) |->
      ($signed(rsp_data_ff[OUT_W-1:0]) <= 16384 && $signed(rsp_data_ff[OUT_W-1:0]) >= -16384))
      else $error("tangent component out of unit range");

   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_OUT))
      else $error("result overwrote a pending item");
endmodule

// ===== tb/tb_checker.sv =====
// Checker: watches both channels, predicts tangent and bitangent, and compares.
module tb_checker #(
   parameter int COORD_WIDTH = 32,
   parameter int REQ_W = 160
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [ttb_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      rsp_tuser,
   output int                        fail_count,
   output int                        pending,
   output int                        tri_count,
   output int                        degen_count
);
   typedef struct packed {
      logic [15:0] bz, by, bx, tz, ty, tx;
      logic        degen;
   } frame_type;

   frame_type frame_q[$];
   logic [1:0] slot;
   logic signed [COORD_WIDTH-1:0] hold_p[6];
   logic signed [COORD_WIDTH-1:0] hold_t[4];

   task automatic report(input string what);
      fail_count++;
      $display("tb: mismatch %s", what);
   endtask

   function automatic logic [127:0] mag128(input logic signed [127:0] v);
      return v[127] ? -v : v;
   endfunction

   // scale to 30-bit peak, floor sqrt length, round each component half up
   function automatic logic unit_vec(input logic signed [127:0] v[3], input logic flip,
                                     output logic [15:0] q[3]);
      logic [127:0] m[3];
      logic [127:0] orv;
      logic [63:0] a[3];
      logic [63:0] sum, len, c, r, b, x;
      int lb, s;
      orv = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag128(v[i]);
         orv |= m[i];
      end
      if (orv == 0) return 0;
      lb = 0;
      for (int i = 0; i < 128; i++) if (orv[i]) lb = i + 1;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         if (lb > 30) begin
            s = lb - 30;
            a[i] = 64'(m[i] >> s);
         end else begin
            a[i] = 64'(m[i] << (30 - lb));
         end
         sum += a[i] * a[i];
      end
      x = sum; r = 0; b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      len = r;
      for (int i = 0; i < 3; i++) begin
         c = (a[i] * 64'd32768 + len) / (2 * len);
         if (v[i] == 0) q[i] = 16'(c);
         else if (v[i][127] ^ flip) q[i] = 16'(-c);
         else q[i] = 16'(c);
      end
      return 1;
   endfunction

   function automatic frame_type solve_frame(input logic [REQ_W-1:0] d);
      logic signed [127:0] e1[3], e2[3], tv[3], bv[3];
      logic signed [127:0] du1, dv1, du2, dv2, det, cur;
      logic [15:0] tq[3], bq[3];
      logic ok;
      frame_type f;
      for (int i = 0; i < 3; i++) begin
         cur = $signed(d[i*COORD_WIDTH +: COORD_WIDTH]);
         e1[i] = 128'(hold_p[3+i]) - 128'(hold_p[i]);
         e2[i] = cur - 128'(hold_p[i]);
      end
      du1 = 128'(hold_t[2]) - 128'(hold_t[0]);
      dv1 = 128'(hold_t[3]) - 128'(hold_t[1]);
      du2 = $signed(d[3*COORD_WIDTH +: COORD_WIDTH]) - 128'(hold_t[0]);
      dv2 = $signed(d[4*COORD_WIDTH +: COORD_WIDTH]) - 128'(hold_t[1]);
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
         tv[i] = dv2 * e1[i] - dv1 * e2[i];
         bv[i] = du1 * e2[i] - du2 * e1[i];
      end
      ok = det != 0;
      if (ok) ok = unit_vec(tv, det[127], tq);
      if (ok) ok = unit_vec(bv, det[127], bq);
      f = '0;
      f.degen = !ok;
      if (ok) begin
         f.tx = tq[0]; f.ty = tq[1]; f.tz = tq[2];
         f.bx = bq[0]; f.by = bq[1]; f.bz = bq[2];
      end
      return f;
   endfunction

   always @(posedge clock) begin
      frame_type got, want;
      if (reset) begin
         slot <= 0;
         fail_count <= 0;
         tri_count <= 0;
         degen_count <= 0;
         frame_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (slot != 2) begin
               for (int i = 0; i < 3; i++)
                  hold_p[slot*3+i] = req_tdata[i*COORD_WIDTH +: COORD_WIDTH];
               hold_t[slot*2] = req_tdata[3*COORD_WIDTH +: COORD_WIDTH];
               hold_t[slot*2+1] = req_tdata[4*COORD_WIDTH +: COORD_WIDTH];
               slot <= slot + 1;
            end else begin
               want = solve_frame(req_tdata);
               frame_q.insert(frame_q.size(), want);
               tri_count <= tri_count + 1;
               if (want.degen) degen_count <= degen_count + 1;
               slot <= 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser};
            if (frame_q.size() == 0) begin
               report("result with nothing expected");
            end else begin
               want = frame_q.pop_front();
               if (got.degen != want.degen) report($sformatf("degenerate %0d exp %0d",
                  got.degen, want.degen));
               if (got.tx != want.tx || got.ty != want.ty || got.tz != want.tz)
                  report($sformatf("tangent %h %h %h exp %h %h %h", got.tx, got.ty,
                     got.tz, want.tx, want.ty, want.tz));
               if (got.bx != want.bx || got.by != want.by || got.bz != want.bz)
                  report($sformatf("bitangent %h %h %h exp %h %h %h", got.bx, got.by,
                     got.bz, want.bx, want.by, want.bz));
            end
         end
      end
   end

   assign pending = frame_q.size();
endmodule

// ===== tb/tb.sv =====
// Testbench top: drives vertex items and a stalling receiver, gives the verdict.
module tb;
   localparam int CW = 32;
   localparam int REQ_W = ((5 * CW + 7) / 8) * 8;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [ttb_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;
   int fail_count, pending, tri_count, degen_count;
   int idle_cycles = 0;
   int rsp_idle = 0;
   bit calm = 0;
   bit long_hold = 0;

   always #5 clock = ~clock;

   triangle_tangent_bitangent #(.COORD_WIDTH(CW)) u_top (.*);

   tb_checker #(.COORD_WIDTH(CW), .REQ_W(REQ_W)) u_chk (.*);

   function automatic logic [31:0] pick_coord(input int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 8) << 16;
         2: return {{16{1'b0}}, 16'($urandom)} - 32'h8000;
         default: return 32'($signed($urandom_range(0, 4000)) - 2000) << 12;
      endcase
   endfunction

   task automatic send(input logic [REQ_W-1:0] d);
      req_tdata = d;
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
   endtask

   task automatic send_vtx(input logic [31:0] x, y, z, u, v);
      send({v, u, z, y, x});
   endtask

   task automatic gap();
      if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset || long_hold) rsp_tready <= 0;
      else if (calm) rsp_tready <= 1;
      else if (rsp_idle > 0) begin
         rsp_tready <= 0;
         rsp_idle <= rsp_idle - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready <= 0;
         rsp_idle <= $urandom_range(0, 15);
      end else rsp_tready <= 1;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || long_hold)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [31:0] c[5];
      int mode;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // ordinary triangle, then extremes, zero det, zero edges, parallel edges, extremes
      send_vtx(0, 0, 0, 0, 0);
      send_vtx(32'h10000, 0, 0, 32'h10000, 0);
      send_vtx(0, 32'h10000, 0, 0, 32'h10000);
      send_vtx(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
      send_vtx(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
      send_vtx(32'hffffffff, 32'h7fffffff, 0, 32'h80000000, 32'h80000000);
      send_vtx(1, 2, 3, 5, 5);
      send_vtx(4, 5, 6, 5, 5);
      send_vtx(7, 8, 9, 6, 6);
      send_vtx(0, 0, 0, 0, 0);
      send_vtx(0, 0, 0, 32'h10000, 0);
      send_vtx(0, 0, 0, 0, 32'h10000);
      send_vtx(0, 0, 0, 0, 0);
      send_vtx(32'h10000, 0, 0, 32'h10000, 32'h20000);
      send_vtx(32'h10000, 0, 0, 32'h20000, 32'h10000);
      send_vtx(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000, 32'h80000000);
      send_vtx(1, 1, 1, 32'h7fffffff, 32'h80000000);
      send_vtx(0, 0, 0, 32'h80000000, 32'h7fffffff);
      for (int n = 0; n < 1150; n++) begin
         if (n == 1050) calm = 1;
         if (n == 300) fork
            begin
               long_hold = 1;
               repeat (3000) @(negedge clock);
               long_hold = 0;
            end
         join_none
         if (n == 600) begin
            wait (pending == 0 && u_chk.slot == 0);
         end
         mode = $urandom_range(0, 3);
         // most coordinates of a vertex share a scale; some are raw noise
         for (int k = 0; k < 5; k++) c[k] = pick_coord($urandom_range(0, 9) == 0 ? 0 : mode);
         send_vtx(c[0], c[1], c[2], c[3], c[4]);
         gap();
      end
      calm = 1;
      wait (pending == 0);
      repeat (600) @(posedge clock);
      $display("tb: %0d vertex items, %0d triangles checked, %0d degenerate",
               1168, tri_count, degen_count);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
